[rtl/core/nalsp_pkg.sv]
// ----------------------------------------------------------------------------
// nalsp_pkg
// Shared types and constants of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package nalsp_pkg;

  // Default depth of the result queue between the scanner and the output side.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Reset value of the split enable register.
  localparam logic SPLIT_ENABLE_RESET = 1'b1;

  // One released byte with its markers.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_start;
    logic       frame_end;
    logic       run_last;
  } res_t;

endpackage

[rtl/core/nalsp_front.sv]
// ----------------------------------------------------------------------------
// nalsp_front
// Accepts frame bytes, holds a three byte lookahead, detects start codes and
// writes each released byte with its markers into the result queue.
// ----------------------------------------------------------------------------
module nalsp_front
  import nalsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       res_push_o,
  output res_t       res_o
);

  typedef struct packed {
    logic       at_start;
    logic       splits;
    logic [1:0] skip;
  } scan_st_t;

  typedef struct packed {
    scan_st_t   st;
    logic       start;
  } rel_t;

  localparam scan_st_t ScanReset = '{at_start: 1'b1, splits: 1'b0, skip: 2'd0};

  // Decides unit_start for the byte b[0], given cnt valid bytes from it on.
  function automatic rel_t release_byte(scan_st_t st, logic en,
                                        logic [3:0][7:0] b, logic [2:0] cnt);
    rel_t       r;
    logic       is3;
    logic       is4;
    logic [1:0] skp;
    is3 = (cnt >= 3'd3) && (b[0] == 8'd0) && (b[1] == 8'd0) && (b[2] == 8'd1);
    is4 = !is3 && (cnt == 3'd4) && (b[0] == 8'd0) && (b[1] == 8'd0) &&
          (b[2] == 8'd0) && (b[3] == 8'd1);
    skp = is4 ? 2'd3 : 2'd2;
    r.st    = st;
    r.start = 1'b0;
    if (st.at_start) begin
      r.start       = 1'b1;
      r.st.at_start = 1'b0;
      r.st.splits   = en && (is3 || is4);
      r.st.skip     = (en && (is3 || is4)) ? skp : 2'd0;
    end else if (st.splits) begin
      if (st.skip != 2'd0) begin
        r.st.skip = st.skip - 2'd1;
      end else if (is3 || is4) begin
        r.start   = 1'b1;
        r.st.skip = skp;
      end
    end
    return r;
  endfunction

  logic            split_en_q;
  scan_st_t        st_q, st_d;
  logic [1:0]      held_q, held_d;
  logic [7:0]      win_q [4];
  logic [7:0]      win_d [4];
  logic            flush_q, flush_d;
  logic [1:0]      idx_q, idx_d;
  logic [2:0]      n_q, n_d;
  logic            in_acc;
  logic            last_out;
  logic [3:0][7:0] scan_b;
  logic [2:0]      scan_cnt;
  logic [2:0]      pos;
  rel_t            rel;

  assign in_ready_o = !flush_q && !q_full_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_out   = flush_q && (({1'b0, idx_q} + 3'd1) == n_q);

  always_comb begin
    scan_b   = '0;
    scan_cnt = 3'd4;
    pos      = 3'd0;
    if (flush_q) begin
      // During the flush the window ends at the frame's last byte.
      for (int k = 0; k < 4; k++) begin
        pos       = {1'b0, idx_q} + 3'(k);
        scan_b[k] = pos[2] ? 8'd0 : win_q[pos[1:0]];
      end
      scan_cnt = n_q - {1'b0, idx_q};
    end else begin
      scan_b[0] = win_q[0];
      scan_b[1] = win_q[1];
      scan_b[2] = win_q[2];
      scan_b[3] = in_byte_i;
    end
    rel = release_byte(st_q, split_en_q, scan_b, scan_cnt);
  end

  always_comb begin
    st_d       = st_q;
    held_d     = held_q;
    win_d      = win_q;
    flush_d    = flush_q;
    idx_d      = idx_q;
    n_d        = n_q;
    res_push_o = 1'b0;
    res_o      = '0;
    if (flush_q) begin
      if (!q_full_i) begin
        res_push_o       = 1'b1;
        res_o.out_byte   = win_q[idx_q];
        res_o.unit_start = rel.start;
        res_o.frame_end  = last_out;
        res_o.run_last   = last_out;
        st_d             = rel.st;
        if (last_out) begin
          flush_d = 1'b0;
          held_d  = 2'd0;
          st_d    = ScanReset;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end else if (in_acc) begin
      if (in_last_i) begin
        win_d[held_q] = in_byte_i;
        n_d           = {1'b0, held_q} + 3'd1;
        idx_d         = 2'd0;
        flush_d       = 1'b1;
      end else if (held_q == 2'd3) begin
        res_push_o       = 1'b1;
        res_o.out_byte   = win_q[0];
        res_o.unit_start = rel.start;
        res_o.frame_end  = 1'b0;
        res_o.run_last   = 1'b1;
        st_d             = rel.st;
        win_d[0]         = win_q[1];
        win_d[1]         = win_q[2];
        win_d[2]         = in_byte_i;
      end else begin
        win_d[held_q] = in_byte_i;
        held_d        = held_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_en_q <= SPLIT_ENABLE_RESET;
      st_q       <= ScanReset;
      held_q     <= 2'd0;
      flush_q    <= 1'b0;
      idx_q      <= 2'd0;
      n_q        <= 3'd1;
    end else begin
      if (cfg_we_i) begin
        split_en_q <= cfg_wdata_i;
      end
      st_q    <= st_d;
      held_q  <= held_d;
      flush_q <= flush_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

`ifndef SYNTHESIS
  a_flush_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (({1'b0, idx_q} < n_q) && (n_q != 3'd0)))
    else $error("flush index beyond the held bytes");
  a_frame_end_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.frame_end) |=> (st_q.at_start && !flush_q && held_q == 2'd0))
    else $error("scanner not rearmed after frame end");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !q_full_i)
    else $error("result written into a full queue");
  a_flush_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> (flush_q && idx_q == 2'd0))
    else $error("frame end did not start the flush");
`endif

endmodule

[rtl/core/nalsp_queue.sv]
// ----------------------------------------------------------------------------
// nalsp_queue
// Short register queue of released bytes; the head drives the result ports.
// ----------------------------------------------------------------------------
module nalsp_queue
  import nalsp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_ptr_match_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wptr_q == rptr_q))
    else $error("pointers disagree on an empty queue");
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !do_pop) |=> $stable(data_o))
    else $error("head entry changed without a pop");
`endif

endmodule

[rtl/core/annexb_nal_unit_splitter.sv]
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits the bytes of a compressed video frame into NAL units at Annex B
// start codes, marking the first byte of each unit and the frame's end.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  config    in         cfg_we_i         cfg_wdata_i (split enable)
//  input     in         push / full      in_byte_i, frame_last_i
//  result    out        empty / pop      out_byte_o, unit_start_o,
//                                        frame_end_o, run_last_o
//
// A byte in the middle of a frame is accepted while the queue has room; once
// three bytes are held each accepted byte writes one result into the queue,
// so the stream runs at one byte per cycle unless the queue is full. A byte
// with frame_last set starts a flush that writes the held bytes plus that
// byte, one per cycle while the queue has room; full stays high meanwhile.
// full also rises when the result queue of QueueDepth entries is full.
// Reset clears the scanner and the queue; split enable resets to one.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
  import nalsp_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       frame_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       unit_start_o,
  output logic       frame_end_o,
  output logic       run_last_o
);

  logic in_ready;
  logic q_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  nalsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (push),
    .in_byte_i   (in_byte_i),
    .in_last_i   (frame_last_i),
    .in_ready_o  (in_ready),
    .q_full_i    (q_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  nalsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign full         = !in_ready;
  assign out_byte_o   = res_out.out_byte;
  assign unit_start_o = res_out.unit_start;
  assign frame_end_o  = res_out.frame_end;
  assign run_last_o   = res_out.run_last;

endmodule
